@@ hw/rtl/srtm_pkg.sv @@
// ---------------------------------------------------------------------------
// srtm_pkg: shared types and constants for the send/receive tag matcher
// Field widths, event kind codes, controller states and the command bundle.
// ---------------------------------------------------------------------------
package srtm_pkg;

  localparam int KIND_W   = 2;
  localparam int RANK_W   = 21;
  localparam int EV_W     = 31;
  localparam int CNT_OUT_W = 7;

  localparam int DEF_STORE_DEPTH = 64;
  localparam int DEF_ID_BITS     = 21;

  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEND  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RECV  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_COMMIT
  } srtm_state_t;

  typedef struct packed {
    logic load_in;
    logic compare;
    logic commit;
  } srtm_cmd_t;

endpackage

@@ hw/rtl/send_recv_tag_matcher_unit.sv @@
// ---------------------------------------------------------------------------
// send_recv_tag_matcher_unit: point-to-point message matcher
// Pairs each send or receive with the oldest pending opposite event by key, else queues or drops it.
// ---------------------------------------------------------------------------
// Each event is latched at the clock edge that accepts it. The parallel key
// compare against every stored entry is registered in the compare state, and
// in the commit state the oldest hit is picked, the store compacted and the
// result registered; the commit waits while the result register is held by
// out_ready. A new event is taken in the cycle after the commit, so an event
// is through the store before the next is accepted. After an event marked
// last the store is empty again; no clearing pass is needed after reset.
module send_recv_tag_matcher_unit #(
  parameter int STORE_DEPTH = srtm_pkg::DEF_STORE_DEPTH,
  parameter int ID_BITS     = srtm_pkg::DEF_ID_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [srtm_pkg::KIND_W-1:0]     in_kind,
  input  logic [srtm_pkg::RANK_W-1:0]     in_own_rank,
  input  logic [srtm_pkg::RANK_W-1:0]     in_peer_rank,
  input  logic [srtm_pkg::RANK_W-1:0]     in_msg_tag,
  input  logic [srtm_pkg::EV_W-1:0]       in_event_index,
  input  logic                            in_last_event,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [srtm_pkg::EV_W-1:0]       out_event_id,
  output logic                            out_matched,
  output logic [srtm_pkg::EV_W-1:0]       out_partner_index,
  output logic                            out_queued,
  output logic                            out_dropped,
  output logic [srtm_pkg::CNT_OUT_W-1:0]  out_pending_sends,
  output logic [srtm_pkg::CNT_OUT_W-1:0]  out_pending_recvs
);
  import srtm_pkg::*;

  srtm_cmd_t cmd;

  srtm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  srtm_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_kind           (in_kind),
    .in_own_rank       (in_own_rank),
    .in_peer_rank      (in_peer_rank),
    .in_msg_tag        (in_msg_tag),
    .in_event_index    (in_event_index),
    .in_last_event     (in_last_event),
    .out_event_id      (out_event_id),
    .out_matched       (out_matched),
    .out_partner_index (out_partner_index),
    .out_queued        (out_queued),
    .out_dropped       (out_dropped),
    .out_pending_sends (out_pending_sends),
    .out_pending_recvs (out_pending_recvs)
  );
endmodule

@@ hw/rtl/srtm_ctrl.sv @@
// ---------------------------------------------------------------------------
// srtm_ctrl: sequencer for the tag matcher
// Accepts a transaction, runs the compare and commit steps and owns out_valid.
// ---------------------------------------------------------------------------
module srtm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output srtm_pkg::srtm_cmd_t cmd
);
  import srtm_pkg::*;

  srtm_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        cmd.compare = 1'b1;
        state_nxt   = ST_COMMIT;
      end
      ST_COMMIT: begin
        // The result register must be free before the store is updated.
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  a_commit_frees: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("result not presented after commit");
  a_compare_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_in |=> state_r == ST_COMPARE)
    else $error("compare step skipped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("accept while busy");
endmodule

@@ hw/rtl/srtm_datapath.sv @@
// ---------------------------------------------------------------------------
// srtm_datapath: pending-event store with parallel key compare
// Entries stay compacted in arrival order; the lowest hit is the oldest.
// ---------------------------------------------------------------------------
module srtm_datapath #(
  parameter int STORE_DEPTH = srtm_pkg::DEF_STORE_DEPTH,
  parameter int ID_BITS     = srtm_pkg::DEF_ID_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  srtm_pkg::srtm_cmd_t             cmd,
  input  logic [srtm_pkg::KIND_W-1:0]     in_kind,
  input  logic [srtm_pkg::RANK_W-1:0]     in_own_rank,
  input  logic [srtm_pkg::RANK_W-1:0]     in_peer_rank,
  input  logic [srtm_pkg::RANK_W-1:0]     in_msg_tag,
  input  logic [srtm_pkg::EV_W-1:0]       in_event_index,
  input  logic                            in_last_event,
  output logic [srtm_pkg::EV_W-1:0]       out_event_id,
  output logic                            out_matched,
  output logic [srtm_pkg::EV_W-1:0]       out_partner_index,
  output logic                            out_queued,
  output logic                            out_dropped,
  output logic [srtm_pkg::CNT_OUT_W-1:0]  out_pending_sends,
  output logic [srtm_pkg::CNT_OUT_W-1:0]  out_pending_recvs
);
  import srtm_pkg::*;

  localparam int KEY_W = 3 * ID_BITS;
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(STORE_DEPTH);

  // Latched transaction.
  logic             act_r, is_send_r, last_r;
  logic [KEY_W-1:0] key_r;
  logic [EV_W-1:0]  ev_r;
  logic [ID_BITS-1:0] snd, rcv;

  // Store.
  logic [KEY_W-1:0] slot_key_r  [STORE_DEPTH];
  logic [EV_W-1:0]  slot_ev_r   [STORE_DEPTH];
  logic             slot_send_r [STORE_DEPTH];
  logic [CNT_W-1:0] used_r, nsend_r, nrecv_r;
  logic [CNT_W-1:0] used_nxt, nsend_nxt, nrecv_nxt;

  logic [STORE_DEPTH-1:0] hit_r, first, ge;
  logic                   any_hit, do_queue;
  logic [EV_W-1:0]        partner;

  always_comb begin
    if (in_kind == KIND_SEND) begin
      snd = in_own_rank[ID_BITS-1:0];
      rcv = in_peer_rank[ID_BITS-1:0];
    end else begin
      snd = in_peer_rank[ID_BITS-1:0];
      rcv = in_own_rank[ID_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r     <= (in_kind == KIND_SEND) || (in_kind == KIND_RECV);
      is_send_r <= (in_kind == KIND_SEND);
      last_r    <= in_last_event;
      key_r     <= {snd, rcv, in_msg_tag[ID_BITS-1:0]};
      ev_r      <= in_event_index;
    end
  end

  // Compare step: one equality per entry, registered.
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        hit_r[i] <= act_r && (CNT_W'(i) < used_r) && (slot_send_r[i] != is_send_r)
                    && (slot_key_r[i] == key_r);
      end
    end
  end

  // Commit step: isolate the oldest hit and the entries at or above it.
  always_comb begin
    first   = hit_r & (~hit_r + 1'b1);
    ge      = ~first + 1'b1;
    any_hit = |hit_r;
    partner = '0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (first[i]) partner = partner | slot_ev_r[i];
    end
    do_queue = act_r && !any_hit && (used_r != FULL);
  end

  always_comb begin
    used_nxt  = used_r;
    nsend_nxt = nsend_r;
    nrecv_nxt = nrecv_r;
    if (any_hit) begin
      used_nxt = used_r - 1'b1;
      if (is_send_r) nrecv_nxt = nrecv_r - 1'b1;
      else           nsend_nxt = nsend_r - 1'b1;
    end else if (do_queue) begin
      used_nxt = used_r + 1'b1;
      if (is_send_r) nsend_nxt = nsend_r + 1'b1;
      else           nrecv_nxt = nrecv_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        if (any_hit && ge[i] && (i < STORE_DEPTH - 1)) begin
          slot_key_r[i]  <= slot_key_r[(i + 1) % STORE_DEPTH];
          slot_ev_r[i]   <= slot_ev_r[(i + 1) % STORE_DEPTH];
          slot_send_r[i] <= slot_send_r[(i + 1) % STORE_DEPTH];
        end else if (do_queue && (used_r == CNT_W'(i))) begin
          slot_key_r[i]  <= key_r;
          slot_ev_r[i]   <= ev_r;
          slot_send_r[i] <= is_send_r;
        end
      end
      out_event_id      <= ev_r;
      out_matched       <= any_hit;
      out_partner_index <= partner;
      out_queued        <= do_queue;
      out_dropped       <= act_r && !any_hit && (used_r == FULL);
      out_pending_sends <= CNT_OUT_W'(nsend_nxt);
      out_pending_recvs <= CNT_OUT_W'(nrecv_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      nsend_r <= '0;
      nrecv_r <= '0;
    end else if (cmd.commit) begin
      if (last_r) begin
        used_r  <= '0;
        nsend_r <= '0;
        nrecv_r <= '0;
      end else begin
        used_r  <= used_nxt;
        nsend_r <= nsend_nxt;
        nrecv_r <= nrecv_nxt;
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= FULL)
    else $error("store fill exceeds depth");
  a_count_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (nsend_r + nrecv_r) == used_r)
    else $error("pending counts disagree with fill");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && last_r) |=> used_r == '0)
    else $error("store not cleared after last transaction");
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> $onehot0({any_hit, do_queue}))
    else $error("match and queue together");
endmodule

@@ test/tb_send_recv_tag_matcher_unit.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_send_recv_tag_matcher_unit: self-checking bench for the tag matcher
// Drives directed and random send/receive/other events with random idling,
// predicts every result with a behavioral pending store, compares whole results.
// ---------------------------------------------------------------------------
module tb_send_recv_tag_matcher_unit;
  import srtm_pkg::*;

  localparam int DEPTH = DEF_STORE_DEPTH;
  localparam int N_RANDOM = 1030;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [RANK_W-1:0] own;
    logic [RANK_W-1:0] peer;
    logic [RANK_W-1:0] tag;
    logic [EV_W-1:0]   ev;
    logic              last;
  } event_t;

  typedef struct packed {
    logic [EV_W-1:0]      event_id;
    logic                 matched;
    logic [EV_W-1:0]      partner;
    logic                 queued;
    logic                 dropped;
    logic [CNT_OUT_W-1:0] n_sends;
    logic [CNT_OUT_W-1:0] n_recvs;
  } match_result_t;

  // A directed row may carry a hand-written result that must also agree.
  typedef struct {
    event_t        ev;
    bit            has_known;
    match_result_t known;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] in_kind = '0;
  logic [RANK_W-1:0] in_own_rank = '0, in_peer_rank = '0, in_msg_tag = '0;
  logic [EV_W-1:0] in_event_index = '0;
  logic in_last_event = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [EV_W-1:0] out_event_id, out_partner_index;
  logic out_matched, out_queued, out_dropped;
  logic [CNT_OUT_W-1:0] out_pending_sends, out_pending_recvs;

  always #5 clk = ~clk;

  send_recv_tag_matcher_unit dut (.*);

  // Pending store: oldest entry at index 0.
  logic             pend_is_send[$];
  logic [62:0]      pend_key[$];
  logic [EV_W-1:0]  pend_ev[$];
  match_result_t    expected_results[$];
  directed_row_t    rows[$];

  int errors = 0, n_accepted = 0, n_results = 0;
  int n_matched = 0, n_queued = 0, n_dropped = 0, n_other = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b0, hold_off = 1'b0, done_sending = 1'b0;

  function automatic match_result_t predict_match(event_t e);
    match_result_t r;
    logic [62:0] key;
    logic want_send;
    int hit, ns, nr;
    r = '0;
    r.event_id = e.ev;
    hit = -1;
    if (e.kind == KIND_SEND || e.kind == KIND_RECV) begin
      key = (e.kind == KIND_SEND) ? {e.own, e.peer, e.tag} : {e.peer, e.own, e.tag};
      want_send = (e.kind == KIND_RECV);
      foreach (pend_key[i]) begin
        if (hit < 0 && pend_is_send[i] == want_send && pend_key[i] == key) hit = i;
      end
      if (hit >= 0) begin
        r.matched = 1'b1;
        r.partner = pend_ev[hit];
        pend_is_send.delete(hit);
        pend_key.delete(hit);
        pend_ev.delete(hit);
      end else if (pend_key.size() < DEPTH) begin
        r.queued = 1'b1;
        pend_is_send.push_back(e.kind == KIND_SEND);
        pend_key.push_back(key);
        pend_ev.push_back(e.ev);
      end else begin
        r.dropped = 1'b1;
      end
    end
    ns = 0;
    nr = 0;
    foreach (pend_is_send[i]) begin
      if (pend_is_send[i]) ns++;
      else nr++;
    end
    r.n_sends = CNT_OUT_W'(ns);
    r.n_recvs = CNT_OUT_W'(nr);
    if (e.last) begin
      pend_is_send.delete();
      pend_key.delete();
      pend_ev.delete();
    end
    return r;
  endfunction

  function automatic void report_mismatch(string what, match_result_t exp_r,
                                          match_result_t got);
    errors++;
    if (errors <= 10)
      $display("%0t mismatch (%s): expected %p, got %p", $realtime, what, exp_r, got);
  endfunction

  // Random ranks and tags come mostly from a tiny pool so that keys collide.
  function automatic logic [RANK_W-1:0] pick_id();
    if ($urandom_range(0, 9) < 8) return RANK_W'($urandom_range(0, 3));
    return RANK_W'($urandom);
  endfunction

  function automatic event_t random_event(int idx);
    event_t e;
    int sel;
    sel = $urandom_range(0, 99);
    e.kind = (sel < 45) ? KIND_SEND : (sel < 90) ? KIND_RECV :
             (sel < 95) ? KIND_OTHER : 2'd3;
    e.own = pick_id();
    e.peer = pick_id();
    e.tag = pick_id();
    e.ev = ($urandom_range(0, 3) == 0) ? EV_W'($urandom) : EV_W'(idx);
    e.last = ($urandom_range(0, 149) == 0);
    return e;
  endfunction

  // Valid stays high after acceptance; the caller drops it when it idles.
  task automatic send_event(event_t e);
    in_valid <= 1'b1;
    {in_kind, in_own_rank, in_peer_rank, in_msg_tag, in_event_index, in_last_event} <= e;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic add_row(event_t e, bit has_known, match_result_t known);
    directed_row_t d;
    d.ev = e;
    d.has_known = has_known;
    d.known = known;
    rows.push_back(d);
  endtask

  function automatic event_t mk(logic [KIND_W-1:0] k, logic [RANK_W-1:0] o,
                                logic [RANK_W-1:0] p, logic [RANK_W-1:0] t,
                                logic [EV_W-1:0] ev, logic last);
    event_t e;
    e = {k, o, p, t, ev, last};
    return e;
  endfunction

  function automatic match_result_t mr(logic [EV_W-1:0] id, logic m, logic [EV_W-1:0] p,
                                       logic q, logic d, int ns, int nr);
    match_result_t r;
    r = {id, m, p, q, d, 7'(ns), 7'(nr)};
    return r;
  endfunction

  // Sender: directed table, random events, then a store-full burst.
  initial begin
    event_t e;
    match_result_t known;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(mk(KIND_OTHER, '1, '1, '1, '1, 1'b0), 1, mr('1, 0, 0, 0, 0, 0, 0));
    add_row(mk(2'd3, 5, 6, 7, 1, 1'b0), 1, mr(1, 0, 0, 0, 0, 0, 0));
    add_row(mk(KIND_RECV, 5, 6, 7, 2, 1'b0), 1, mr(2, 0, 0, 1, 0, 0, 1));
    add_row(mk(KIND_SEND, 6, 5, 7, 3, 1'b0), 1, mr(3, 1, 2, 0, 0, 0, 0));
    add_row(mk(KIND_SEND, '1, '1, '1, '1, 1'b0), 1, mr('1, 0, 0, 1, 0, 1, 0));
    add_row(mk(KIND_SEND, '1, '1, '1, 4, 1'b0), 1, mr(4, 0, 0, 1, 0, 2, 0));
    add_row(mk(KIND_RECV, '1, '1, '1, 0, 1'b0), 1, mr(0, 1, '1, 0, 0, 1, 0));
    add_row(mk(KIND_SEND, 0, 0, 0, 0, 1'b0), 0, known);
    add_row(mk(KIND_SEND, 0, 0, 0, 5, 1'b0), 0, known);
    add_row(mk(KIND_RECV, 1, 0, 0, 6, 1'b0), 0, known);
    add_row(mk(KIND_RECV, 0, 0, 0, 7, 1'b0), 0, known);
    add_row(mk(KIND_SEND, 0, 0, 1, 8, 1'b0), 0, known);
    // Last event reports counts before the store is flushed.
    add_row(mk(KIND_RECV, 0, 0, 9, 9, 1'b1), 0, known);
    add_row(mk(KIND_RECV, 0, 0, 1, 10, 1'b0), 1, mr(10, 0, 0, 1, 0, 0, 1));
    add_row(mk(KIND_SEND, 'h15555, 'h0AAAA, 'h15555, 'h2AAAAAAA, 1'b0), 0, known);
    add_row(mk(KIND_RECV, 'h0AAAA, 'h15555, 'h15555, 'h55555555, 1'b1), 0, known);

    foreach (rows[i]) send_event(rows[i].ev);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) no_idle = 1'b1;
      if (i == 450) no_idle = 1'b0;
      if (i == 600) hold_off = 1'b1;
      e = random_event(i + 100);
      send_event(e);
      if (!no_idle && $urandom_range(0, 99) < 14) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
    end

    // Fill the store past its depth with unmatched sends, then flush it.
    for (int i = 0; i < DEPTH + 3; i++)
      send_event(mk(KIND_SEND, RANK_W'(100 + i), 7, 7, EV_W'(5000 + i), i == DEPTH + 2));
    in_valid <= 1'b0;
    done_sending = 1'b1;
  end

  // Receiver: random stalls, one long hold-off that stalls the matcher.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      out_ready <= no_idle || ($urandom_range(0, 99) >= 14);
    end
  end

  // Predictor on the input side, checker on the output side.
  always @(posedge clk) begin
    match_result_t got, exp_r;
    event_t e;
    if (rst_n && in_valid && in_ready) begin
      e = {in_kind, in_own_rank, in_peer_rank, in_msg_tag, in_event_index, in_last_event};
      exp_r = predict_match(e);
      if (n_accepted < rows.size() && rows[n_accepted].has_known &&
          rows[n_accepted].known != exp_r)
        report_mismatch("table vs predictor", rows[n_accepted].known, exp_r);
      expected_results.push_back(exp_r);
      n_accepted++;
    end
    if (rst_n && out_valid && out_ready) begin
      got = {out_event_id, out_matched, out_partner_index, out_queued, out_dropped,
             out_pending_sends, out_pending_recvs};
      n_results++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", '0, got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got != exp_r) report_mismatch("result", exp_r, got);
        if (got.matched) n_matched++;
        if (got.queued) n_queued++;
        if (got.dropped) n_dropped++;
        if (!got.matched && !got.queued && !got.dropped) n_other++;
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (done_sending && expected_results.size() == 0);
    repeat (20) @(posedge clk);
    $display("Covered %0d events: %0d matched, %0d queued, %0d dropped, %0d ignored.",
             n_results, n_matched, n_queued, n_dropped, n_other);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog expired with %0d results outstanding.", expected_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
